### rtl/swfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swfc_pkg;

   // CRC-8 as used on the sensor bus: polynomial x^8 + x^5 + x^4 + 1, MSB first.
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Scale factors for the fixed-point conversions.
   localparam logic [31:0] TEMP_SPAN   = 32'd17500;
   localparam logic [31:0] HUMID_SPAN  = 32'd10000;
   localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

   // Values of the mode register.
   localparam logic MODE_CONVERT = 1'b0;
   localparam logic MODE_GAS     = 1'b1;

   // Position of a byte within the six-byte response.
   typedef enum logic [2:0] {
      POS_WORD1_HI = 3'd0,
      POS_WORD1_LO = 3'd1,
      POS_CRC1     = 3'd2,
      POS_WORD2_HI = 3'd3,
      POS_WORD2_LO = 3'd4,
      POS_CRC2     = 3'd5
   } byte_pos_type;

   // One byte through the CRC, eight shifts of a narrow value.
   function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

   // floor(x / 65535) for x below 2^32 with quotient below 2^16:
   // (x + (x >> 16) + 1) >> 16.
   function automatic logic [15:0] div_65535(logic [31:0] x);
      logic [31:0] sum;
      sum = x + {16'd0, x[31:16]} + 32'd1;
      return sum[31:16];
   endfunction

   function automatic logic [14:0] temp_scale(logic [15:0] raw);
      logic [31:0] prod;
      logic [15:0] quot;
      prod = TEMP_SPAN * {16'd0, raw};
      quot = div_65535(prod);
      return quot[14:0];
   endfunction

   function automatic logic [13:0] humid_scale(logic [15:0] raw);
      logic [31:0] prod;
      logic [15:0] quot;
      prod = HUMID_SPAN * {16'd0, raw};
      quot = div_65535(prod);
      return quot[13:0];
   endfunction

endpackage

`default_nettype wire

### rtl/swfc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte channel into the checker.
interface swfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Result channel out of the checker.
interface swfc_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic [15:0]        first_word;
   logic [15:0]        second_word;
   logic signed [14:0] temp_centi;
   logic [13:0]        humid_centi;

   modport source (output valid, output status, output first_word, output second_word,
                   output temp_centi, output humid_centi, input ready);
   modport sink   (input valid, input status, input first_word, input second_word,
                   input temp_centi, input humid_centi, output ready);
endinterface

`default_nettype wire

### rtl/sensor_word_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// req_chan  in         rx_byte[7:0], frame_start
// rsp_chan  out        status, first_word[15:0], second_word[15:0],
//                      temp_centi[14:0] signed, humid_centi[13:0]
// csr_*     in         csr_write_enable, csr_write_data = sensor_mode
//
// One byte is taken per clock cycle unless the byte channel stalls. The CRC
// update, word assembly and the conversions to centidegrees and centipercent
// sit between the frame state registers and the result register, so a result
// appears in the cycle after the sixth byte of a frame is accepted.
// Reset is synchronous and clears the frame state, the mode and the result valid.
// The byte channel only stalls while the position sits at the sixth byte of a
// frame and the previous result is still held and not being taken; a byte
// carrying a frame start waits there too.

module sensor_word_frame_checker
   import swfc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   swfc_req_if.sink   req_chan,
   swfc_rsp_if.source rsp_chan,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data
);

   // Frame state.
   byte_pos_type byte_pos_ff, byte_pos_in;
   logic [7:0]   crc_run_ff, crc_run_in;
   logic [15:0]  word_one_ff, word_one_in;
   logic [7:0]   word_two_high_ff, word_two_high_in;
   logic [7:0]   word_two_low_ff, word_two_low_in;
   logic         crc_failed_ff, crc_failed_in;
   logic         sensor_mode_ff, sensor_mode_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_first_ff, rsp_first_in;
   logic [15:0]        rsp_second_ff, rsp_second_in;
   logic signed [14:0] rsp_temp_ff, rsp_temp_in;
   logic [13:0]        rsp_humid_ff, rsp_humid_in;

   logic               req_fire;
   logic               restart;
   byte_pos_type       eff_pos;
   logic [7:0]         crc_base;
   logic               failed_base;
   logic [7:0]         crc_next;
   logic               frame_done;
   logic [15:0]        word_two;
   logic signed [15:0] temp_wide;

   // A byte at the sixth position, even one carrying a frame start, needs the result
   // register to be free; every other byte is always taken.
   assign req_chan.ready = !(byte_pos_ff == POS_CRC2 && rsp_valid_ff && !rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // A frame start, or a position that should never occur, restarts the frame.
   assign restart     = req_chan.frame_start || (byte_pos_ff > POS_CRC2);
   assign eff_pos     = restart ? POS_WORD1_HI : byte_pos_ff;
   assign crc_base    = restart ? CRC_INIT : crc_run_ff;
   assign failed_base = restart ? 1'b0 : crc_failed_ff;
   assign crc_next    = crc8_step(crc_base, req_chan.rx_byte);
   assign frame_done  = req_fire && (eff_pos == POS_CRC2);
   assign word_two    = {word_two_high_ff, word_two_low_ff};

   always_comb begin
      byte_pos_in      = byte_pos_ff;
      crc_run_in       = crc_run_ff;
      word_one_in      = word_one_ff;
      word_two_high_in = word_two_high_ff;
      word_two_low_in  = word_two_low_ff;
      crc_failed_in    = crc_failed_ff;
      if (req_fire) begin
         byte_pos_in   = byte_pos_type'(eff_pos + 3'd1);
         crc_run_in    = crc_next;
         crc_failed_in = failed_base;
         unique case (eff_pos)
            POS_WORD1_HI: begin
               word_one_in = {req_chan.rx_byte, word_one_ff[7:0]};
            end
            POS_WORD1_LO: begin
               word_one_in = {word_one_ff[15:8], req_chan.rx_byte};
            end
            POS_CRC1: begin
               // The received CRC byte is compared, not folded in.
               crc_failed_in = failed_base || (crc_base != req_chan.rx_byte);
               crc_run_in    = CRC_INIT;
            end
            POS_WORD2_HI: begin
               word_two_high_in = req_chan.rx_byte;
            end
            POS_WORD2_LO: begin
               word_two_low_in = req_chan.rx_byte;
            end
            POS_CRC2: begin
               byte_pos_in   = POS_WORD1_HI;
               crc_run_in    = CRC_INIT;
               crc_failed_in = 1'b0;
            end
            default: begin
               byte_pos_in = POS_WORD1_HI;
            end
         endcase
      end
   end

   // The result fields change only when a frame closes, so a result that is
   // still waiting keeps its payload while the next frame is gathered.
   always_comb begin
      temp_wide     = $signed({1'b0, temp_scale(word_one_ff)}) - TEMP_OFFSET;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_humid_in  = rsp_humid_ff;
      if (frame_done) begin
         rsp_status_in = failed_base || (crc_base != req_chan.rx_byte);
         rsp_first_in  = word_one_ff;
         rsp_second_in = word_two;
         if (sensor_mode_ff == MODE_CONVERT) begin
            rsp_temp_in  = temp_wide[14:0];
            rsp_humid_in = humid_scale(word_two);
         end else begin
            rsp_temp_in  = '0;
            rsp_humid_in = '0;
         end
      end
   end

   always_comb begin
      if (frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign sensor_mode_in = csr_write_enable ? csr_write_data : sensor_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff      <= POS_WORD1_HI;
         crc_run_ff       <= CRC_INIT;
         word_one_ff      <= '0;
         word_two_high_ff <= '0;
         word_two_low_ff  <= '0;
         crc_failed_ff    <= 1'b0;
         sensor_mode_ff   <= MODE_CONVERT;
         rsp_valid_ff     <= 1'b0;
      end else begin
         byte_pos_ff      <= byte_pos_in;
         crc_run_ff       <= crc_run_in;
         word_one_ff      <= word_one_in;
         word_two_high_ff <= word_two_high_in;
         word_two_low_ff  <= word_two_low_in;
         crc_failed_ff    <= crc_failed_in;
         sensor_mode_ff   <= sensor_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_humid_ff  <= rsp_humid_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.first_word  = rsp_first_ff;
   assign rsp_chan.second_word = rsp_second_ff;
   assign rsp_chan.temp_centi  = rsp_temp_ff;
   assign rsp_chan.humid_centi = rsp_humid_ff;

   // The position counter stays within the six bytes of a frame.
   assert property (@(posedge clock) disable iff (reset) byte_pos_ff <= POS_CRC2)
      else $error("byte position left the frame");

   // Closing a frame always leaves a result waiting.
   assert property (@(posedge clock) disable iff (reset) frame_done |=> rsp_valid_ff)
      else $error("closed frame produced no result");

   // A closing byte is never taken while an unread result would be overwritten.
   assert property (@(posedge clock) disable iff (reset)
                    !(frame_done && rsp_valid_ff && !rsp_chan.ready))
      else $error("result overwritten before it was taken");

   // After a frame closes the CRC and position restart.
   assert property (@(posedge clock) disable iff (reset)
                    frame_done |=> (crc_run_ff == CRC_INIT && byte_pos_ff == POS_WORD1_HI
                                    && !crc_failed_ff))
      else $error("frame state not restarted after the last byte");

endmodule

`default_nettype wire

### dv/frame_result_checker.sv
`timescale 1ns / 1ps

// CRC helpers shared by the stimulus and the checker of the testbench.
package frame_crc_pkg;

   localparam logic [7:0] CRC_SEED = 8'hFF;
   localparam logic [7:0] CRC_GEN  = 8'h31;

   function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) begin
         r = r[7] ? ((r << 1) ^ CRC_GEN) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic [7:0] word_crc(logic [15:0] word);
      return crc8_byte(crc8_byte(CRC_SEED, word[15:8]), word[7:0]);
   endfunction

endpackage

// Watches both channels, predicts each frame result and compares it field by field.
module frame_result_checker
   import swfc_pkg::*;
   import frame_crc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   swfc_req_if       req_mon,
   swfc_rsp_if       rsp_mon,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data,
   output int        outstanding,
   output int        failures,
   output int        frames_checked,
   output int        flagged_frames
);

   localparam int unsigned TEMP_SPAN_CENTI   = 17500;
   localparam int unsigned HUMID_SPAN_CENTI  = 10000;
   localparam int unsigned FULL_SCALE        = 65535;
   localparam int          TEMP_OFFSET_CENTI = 4500;

   typedef struct packed {
      logic               status;
      logic [15:0]        first_word;
      logic [15:0]        second_word;
      logic signed [14:0] temp_centi;
      logic [13:0]        humid_centi;
   } frame_result_type;

   frame_result_type expected_frames[$];

   logic         sensor_mode;
   byte_pos_type pos;
   logic [7:0]   crc;
   logic [15:0]  word1;
   logic [7:0]   w2_hi;
   logic [7:0]   w2_lo;
   logic         crc_bad;
   int           fail_total;
   int           checked_total;
   int           flagged_total;

   task automatic absorb_byte(input logic [7:0] b, input logic start);
      frame_result_type r;
      logic [15:0]      second;
      int unsigned      t_scaled;
      int unsigned      h_scaled;
      // A start marker, or a position that should never occur, begins a fresh frame.
      if (start || pos > POS_CRC2) begin
         pos     = POS_WORD1_HI;
         crc     = CRC_SEED;
         crc_bad = 1'b0;
      end
      case (pos)
         POS_WORD1_HI: begin
            crc         = crc8_byte(crc, b);
            word1[15:8] = b;
         end
         POS_WORD1_LO: begin
            crc        = crc8_byte(crc, b);
            word1[7:0] = b;
         end
         POS_CRC1: begin
            if (crc != b) crc_bad = 1'b1;
            crc = CRC_SEED;
         end
         POS_WORD2_HI: begin
            crc   = crc8_byte(crc, b);
            w2_hi = b;
         end
         POS_WORD2_LO: begin
            crc   = crc8_byte(crc, b);
            w2_lo = b;
         end
         default: begin
            second        = {w2_hi, w2_lo};
            r.status      = crc_bad || (crc != b);
            r.first_word  = word1;
            r.second_word = second;
            if (sensor_mode == MODE_CONVERT) begin
               t_scaled      = (TEMP_SPAN_CENTI * word1) / FULL_SCALE;
               h_scaled      = (HUMID_SPAN_CENTI * second) / FULL_SCALE;
               r.temp_centi  = 15'(int'(t_scaled) - TEMP_OFFSET_CENTI);
               r.humid_centi = 14'(h_scaled);
            end else begin
               r.temp_centi  = '0;
               r.humid_centi = '0;
            end
            expected_frames.push_back(r);
            crc     = CRC_SEED;
            crc_bad = 1'b0;
         end
      endcase
      pos = (pos == POS_CRC2) ? POS_WORD1_HI : byte_pos_type'(pos + 3'd1);
   endtask

   task automatic compare_frame(input frame_result_type got);
      frame_result_type want;
      if (expected_frames.size() == 0) begin
         $error("result beat with no frame pending: first_word %h", got.first_word);
         fail_total++;
         return;
      end
      want = expected_frames.pop_front();
      checked_total++;
      if (want.status) flagged_total++;
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         fail_total++;
      end
      if (got.first_word !== want.first_word) begin
         $error("first_word: expected %h, actual %h", want.first_word, got.first_word);
         fail_total++;
      end
      if (got.second_word !== want.second_word) begin
         $error("second_word: expected %h, actual %h", want.second_word, got.second_word);
         fail_total++;
      end
      if (got.temp_centi !== want.temp_centi) begin
         $error("temp_centi: expected %0d, actual %0d", want.temp_centi, got.temp_centi);
         fail_total++;
      end
      if (got.humid_centi !== want.humid_centi) begin
         $error("humid_centi: expected %0d, actual %0d", want.humid_centi, got.humid_centi);
         fail_total++;
      end
   endtask

   initial begin
      fail_total     = 0;
      checked_total  = 0;
      flagged_total  = 0;
      outstanding    = 0;
      failures       = 0;
      frames_checked = 0;
      flagged_frames = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         sensor_mode = MODE_CONVERT;
         pos         = POS_WORD1_HI;
         crc         = CRC_SEED;
         word1       = '0;
         w2_hi       = '0;
         w2_lo       = '0;
         crc_bad     = 1'b0;
         expected_frames.delete();
      end else begin
         if (csr_write_enable) sensor_mode = csr_write_data;
         if (req_mon.valid && req_mon.ready) absorb_byte(req_mon.rx_byte, req_mon.frame_start);
         if (rsp_mon.valid && rsp_mon.ready) begin
            compare_frame({rsp_mon.status, rsp_mon.first_word, rsp_mon.second_word,
                           rsp_mon.temp_centi, rsp_mon.humid_centi});
         end
      end
      outstanding    <= expected_frames.size();
      failures       <= fail_total;
      frames_checked <= checked_total;
      flagged_frames <= flagged_total;
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

// Top of the testbench. It produces the byte stream and the result-side back
// pressure, writes the mode register between phases and gives the verdict.
// All prediction and comparison happens in the checker instantiated below.
module tb;
   import swfc_pkg::*;
   import frame_crc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 8;
   localparam int PHASE_BYTES  = 66;
   localparam int SETTLE_ticks = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data   = 1'b0;

   // When set, neither side inserts idle cycles, so beats run back to back.
   bit no_idle = 1'b0;

   int cycles     = 0;
   int bytes_sent = 0;
   int outstanding;
   int failures;
   int frames_checked;
   int flagged_frames;

   swfc_req_if req_chan();
   swfc_rsp_if rsp_chan();

   always #6 clock = ~clock;

   sensor_word_frame_checker dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .outstanding      (outstanding),
      .failures         (failures),
      .frames_checked   (frames_checked),
      .flagged_frames   (flagged_frames)
   );

   // Watchdog: a hung handshake must not keep the run alive for ever.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Sends one byte beat. Valid stays high after acceptance so that a following
   // beat without a gap goes out on the very next edge; it is only lowered here
   // when a gap is drawn, so it never sees two assignments in one time step.
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= b;
      req_chan.frame_start <= start;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // Sends a full six-byte frame. Bit 0 of corrupt spoils the first word's CRC
   // byte and bit 1 the second's, by a non-zero flip so that the check must fail.
   task automatic send_frame(input logic [15:0] w1, input logic [15:0] w2,
                             input logic start, input logic [1:0] corrupt);
      logic [7:0] c1;
      logic [7:0] c2;
      c1 = word_crc(w1);
      c2 = word_crc(w2);
      if (corrupt[0]) c1 ^= 8'($urandom_range(1, 255));
      if (corrupt[1]) c2 ^= 8'($urandom_range(1, 255));
      send_byte(w1[15:8], start);
      send_byte(w1[7:0], 1'b0);
      send_byte(c1, 1'b0);
      send_byte(w2[15:8], 1'b0);
      send_byte(w2[7:0], 1'b0);
      send_byte(c2, 1'b0);
   endtask

   // Mostly uniform words, with the ends of the scale and the mid-point mixed in.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         4:       return 16'h0001;
         default: return 16'($urandom());
      endcase
   endfunction

   // Stops the byte stream, waits until every predicted result has been taken,
   // and then lets a few more cycles pass so that a stray extra beat is seen.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_ticks) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: a fresh stall is drawn for every result beat.
   initial begin : rsp_drive
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin : stimulus
      int   phase_start;
      int   k;
      logic realign;
      req_chan.valid       = 1'b0;
      req_chan.rx_byte     = 8'h00;
      req_chan.frame_start = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, conversion mode. The all-zero frame gives the bottom of
      // both scales; the all-ones frame follows without a start marker and so
      // relies on the position wrapping after a complete frame.
      write_mode(MODE_CONVERT);
      send_frame(16'h0000, 16'h0000, 1'b1, 2'b00);
      send_frame(16'hFFFF, 16'hFFFF, 1'b0, 2'b00);
      // A partial frame abandoned by a new start marker, whose first CRC is wrong.
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_frame(16'hBEEF, 16'h6666, 1'b1, 2'b01);
      drain_results();

      // Gas mode: raw words only, here with a bad second CRC.
      write_mode(MODE_GAS);
      send_frame(16'h8000, 16'h7FFF, 1'b1, 2'b10);
      drain_results();

      // Random part. Each phase alternates the mode, one phase in four runs
      // with no idling at all, and each ends by draining every result before
      // the register is touched again.
      for (int phase = 0; phase < PHASES; phase++) begin
         no_idle = (phase % 4 == 3);
         write_mode((phase % 2 == 0) ? MODE_CONVERT : MODE_GAS);
         phase_start = bytes_sent;
         realign     = 1'b1;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            case ($urandom_range(0, 9))
               0: begin
                  // Noise: a few loose bytes, start markers at random.
                  k = $urandom_range(1, 5);
                  repeat (k) send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
                  realign = 1'b1;
               end
               1: begin
                  send_frame(pick_word(), pick_word(),
                             realign | 1'($urandom_range(0, 1)),
                             2'($urandom_range(1, 3)));
                  realign = 1'b0;
               end
               default: begin
                  send_frame(pick_word(), pick_word(),
                             realign | 1'($urandom_range(0, 1)), 2'b00);
                  realign = 1'b0;
               end
            endcase
         end
         drain_results();
      end
      no_idle = 1'b0;

      $display("Sent %0d byte beats over %0d random phases in both sensor modes.",
               bytes_sent, PHASES);
      $display("Checked %0d frame results, %0d of them with a CRC mismatch.",
               frames_checked, flagged_frames);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
